/* rtl/core/checked_signed_integer_alu_defines.svh */
// Assertion macros for the checked signed integer ALU
`ifndef CHECKED_SIGNED_INTEGER_ALU_DEFINES_SVH
`define CHECKED_SIGNED_INTEGER_ALU_DEFINES_SVH

// Check a property on every rising clock edge, ignored during reset
`define CSIA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property that holds even while reset is active
`define CSIA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/csia_pkg.sv */
// Package: types, codes and widths for the checked signed integer ALU
`timescale 1ns / 1ps
`default_nettype none
package csia_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned ProdWidth = 2 * DataWidth;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_NEG = 4'd5,
    OP_ABS = 4'd6,
    OP_INC = 4'd7,
    OP_DEC = 4'd8,
    OP_CMP = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_DIVZ  = 2'd2,
    ST_BADOP = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]                  op;
    logic signed [DataWidth-1:0] lhs;
    logic signed [DataWidth-1:0] rhs;
  } req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result;
    logic [1:0]                  status;
  } rsp_t;

endpackage
`default_nettype wire

/* rtl/core/checked_signed_integer_alu.sv */
// In order: capture register, decode, multiply and divider stages, output register.
// Throughput: one request per cycle while the output is not stalled; the divider is
// unrolled into one stage per quotient bit and the 32x32 multiplier has its own stage.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "checked_signed_integer_alu_defines.svh"
module checked_signed_integer_alu
  import csia_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_rsp_o
);

  localparam int unsigned NStages = DataWidth + 2;
  localparam logic [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic [DataWidth-1:0] MaxVal = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic [DataWidth-1:0] AllOne = {DataWidth{1'b1}};
  localparam logic [DataWidth-1:0] One    = {{(DataWidth-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic [3:0]           op;
    logic                 na;
    logic                 nb;
    logic [DataWidth-1:0] magb;
    logic [DataWidth-1:0] r;
    logic [1:0]           st;
    logic [ProdWidth-1:0] prod;
    logic [DataWidth-1:0] rem;
    logic [DataWidth-1:0] quo;
  } pipe_t;

  logic                 en;
  logic                 s0_valid_q;
  req_t                 s0_q;
  logic [NStages-1:0]   vld_q;
  pipe_t                pipe_q [NStages];
  pipe_t                p1_d;
  logic                 out_valid_q;
  rsp_t                 out_q;
  rsp_t                 out_d;

  // Advance everything together whenever the output can move
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= in_req_i;
    end
  end

  // Decode: magnitudes, simple operations and early status
  always_comb begin
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
    logic [DataWidth-1:0] sum;
    logic [DataWidth-1:0] dif;
    a = s0_q.lhs;
    b = s0_q.rhs;
    sum = a + b;
    dif = a - b;
    p1_d       = '0;
    p1_d.op    = s0_q.op;
    p1_d.na    = a[DataWidth-1];
    p1_d.nb    = b[DataWidth-1];
    p1_d.magb  = b[DataWidth-1] ? (~b + One) : b;
    p1_d.quo   = a[DataWidth-1] ? (~a + One) : a;
    p1_d.st    = ST_OK;
    unique case (s0_q.op)
      OP_ADD: begin
        p1_d.r = sum;
        if (a[DataWidth-1] == b[DataWidth-1] && sum[DataWidth-1] != a[DataWidth-1]) begin
          p1_d.st = ST_OVF;
        end
      end
      OP_SUB: begin
        p1_d.r = dif;
        if (a[DataWidth-1] != b[DataWidth-1] && dif[DataWidth-1] != a[DataWidth-1]) begin
          p1_d.st = ST_OVF;
        end
      end
      OP_MUL: ;
      OP_DIV: begin
        if (b == '0) begin
          p1_d.st = ST_DIVZ;
        end else if (a == MinVal && b == AllOne) begin
          p1_d.st = ST_OVF;
        end
      end
      OP_MOD: begin
        if (b == '0) begin
          p1_d.st = ST_DIVZ;
        end
      end
      OP_NEG: begin
        if (a == MinVal) p1_d.st = ST_OVF;
        else p1_d.r = ~a + One;
      end
      OP_ABS: begin
        if (a == MinVal) p1_d.st = ST_OVF;
        else p1_d.r = a[DataWidth-1] ? (~a + One) : a;
      end
      OP_INC: begin
        if (a == MaxVal) p1_d.st = ST_OVF;
        else p1_d.r = a + One;
      end
      OP_DEC: begin
        if (a == MinVal) p1_d.st = ST_OVF;
        else p1_d.r = a - One;
      end
      OP_CMP: begin
        if (a == b) p1_d.r = '0;
        else if ($signed(a) < $signed(b)) p1_d.r = AllOne;
        else p1_d.r = One;
      end
      default: begin
        p1_d.st = ST_BADOP;
      end
    endcase
  end

  // Valid bits of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStages-2:0], s0_valid_q};
    end
  end

  // Decode stage and multiply stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q[0].op   <= p1_d.op;
      pipe_q[0].na   <= p1_d.na;
      pipe_q[0].nb   <= p1_d.nb;
      pipe_q[0].magb <= p1_d.magb;
      pipe_q[0].r    <= p1_d.r;
      pipe_q[0].st   <= p1_d.st;
      pipe_q[0].prod <= p1_d.prod;
      pipe_q[0].rem  <= p1_d.rem;
      pipe_q[0].quo  <= p1_d.quo;

      pipe_q[1].op   <= pipe_q[0].op;
      pipe_q[1].na   <= pipe_q[0].na;
      pipe_q[1].nb   <= pipe_q[0].nb;
      pipe_q[1].magb <= pipe_q[0].magb;
      pipe_q[1].r    <= pipe_q[0].r;
      pipe_q[1].st   <= pipe_q[0].st;
      pipe_q[1].prod <= ProdWidth'(pipe_q[0].quo) * ProdWidth'(pipe_q[0].magb);
      pipe_q[1].rem  <= '0;
      pipe_q[1].quo  <= pipe_q[0].quo;
    end
  end

  // Restoring divider: one quotient bit per stage
  for (genvar k = 2; k < NStages; k++) begin : g_div
    logic [DataWidth:0] trial;
    logic [DataWidth:0] diff;
    assign trial = {pipe_q[k-1].rem, pipe_q[k-1].quo[DataWidth-1]};
    assign diff  = trial - {1'b0, pipe_q[k-1].magb};

    always_ff @(posedge clk_i) begin
      if (en) begin
        pipe_q[k].op   <= pipe_q[k-1].op;
        pipe_q[k].na   <= pipe_q[k-1].na;
        pipe_q[k].nb   <= pipe_q[k-1].nb;
        pipe_q[k].magb <= pipe_q[k-1].magb;
        pipe_q[k].r    <= pipe_q[k-1].r;
        pipe_q[k].st   <= pipe_q[k-1].st;
        pipe_q[k].prod <= pipe_q[k-1].prod;
        pipe_q[k].rem  <= diff[DataWidth] ? trial[DataWidth-1:0] : diff[DataWidth-1:0];
        pipe_q[k].quo  <= {pipe_q[k-1].quo[DataWidth-2:0], ~diff[DataWidth]};
      end
    end
  end

  // Resolve product range, apply signs, force zero on error
  always_comb begin
    pipe_t                l;
    logic [DataWidth-1:0] lo;
    logic                 mneg;
    l    = pipe_q[NStages-1];
    lo   = l.prod[DataWidth-1:0];
    mneg = (l.na != l.nb) && (l.prod != '0);
    out_d.status = l.st;
    out_d.result = l.r;
    unique case (l.op)
      OP_MUL: begin
        if (l.prod[ProdWidth-1:DataWidth] != '0 || lo > (mneg ? MinVal : MaxVal)) begin
          out_d.status = ST_OVF;
        end else begin
          out_d.result = mneg ? (~lo + One) : lo;
        end
      end
      OP_DIV: out_d.result = (l.na != l.nb) ? (~l.quo + One) : l.quo;
      OP_MOD: out_d.result = l.na ? (~l.rem + One) : l.rem;
      default: ;
    endcase
    if (out_d.status != ST_OK) begin
      out_d.result = '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[NStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  `CSIA_ASSERT(a_err_zero, out_valid_o && out_rsp_o.status != ST_OK |-> out_rsp_o.result == '0, "nonzero result with error status")
  `CSIA_ASSERT(a_last_moves, vld_q[NStages-1] && en |=> out_valid_o, "last stage item lost")
  `CSIA_ASSERT(a_rem_bound, vld_q[NStages-1] && pipe_q[NStages-1].magb != '0 |-> pipe_q[NStages-1].rem < pipe_q[NStages-1].magb, "divider remainder out of range")
  `CSIA_ASSERT(a_stall_hold, !en |=> $stable(vld_q[0]) && $stable(s0_valid_q), "pipeline moved during stall")

endmodule
`default_nettype wire
